### rtl/ise_pkg.sv
`default_nettype none

package ise_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // Control broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic  ins;    // insert the broadcast value this cycle
    logic  shift;  // move every entry one place toward cell 0
    data_t value;  // value being inserted
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/ise_ifs.sv
`default_nettype none

interface ise_in_if;
  logic              valid;
  logic              ready;
  ise_pkg::data_t    value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ise_out_if;
  logic              valid;
  logic              ready;
  ise_pkg::data_t    sorted_value;
  logic              final_res;
  logic              overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

`default_nettype wire

### rtl/ise_cell.sv
`default_nettype none

// One entry of the sorted chain.
module ise_cell (
  input  wire logic                clk_i,
  input  wire ise_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                occ_i,       // entry holds a value
  input  wire logic                left_gt_i,   // lower neighbor moves up
  input  wire ise_pkg::data_t      left_val_i,
  input  wire ise_pkg::data_t      right_val_i,
  output      logic                gt_o,
  output      ise_pkg::data_t      val_o
);

  ise_pkg::data_t val_q, val_d;

  // Empty entries count as greater than anything
  assign gt_o = !occ_i || (val_q > ctrl_i.value);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && gt_o) begin
      val_d = left_gt_i ? left_val_i : ctrl_i.value;
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

### rtl/insertion_sort_engine_top.sv
`default_nettype none

// Channel | Dir | Payload                              | Handshake
// in_i    | in  | value[31:0] signed, last             | valid/ready
// out_o   | out | sorted_value[31:0], final_res, ovfl  | valid/ready
//
// Fill: one item per cycle; every cell compares the broadcast value at once
// and the strictly greater entries move up one place (stable order).
// Drain: after an item with last, K results leave from cell 0, one per
// cycle while out_o.ready is high; the chain shifts down on each take.
// in_i.ready is low during drain, so the next set waits until all K kept
// results (K = min(N, MAX_ITEMS) of a set of N items) have been taken.
// Reset clears only the count, the drop flag and the state; no clearing pass.
// Stalls on out_o freeze the chain with the head result held at the output.
module insertion_sort_engine_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ise_in_if.sink    in_i,
  ise_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ITEMS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  // sequencer states
  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;

  ise_pkg::cell_ctrl_t ctrl;
  ise_pkg::data_t      cell_val [MAX_ITEMS];
  logic                cell_gt  [MAX_ITEMS];

  logic in_acc, out_acc, has_room;

  assign in_i.ready = (state_q == ST_FILL);
  assign in_acc     = in_i.valid && in_i.ready;
  assign has_room   = (count_q < CntMax);

  assign out_o.valid        = (state_q == ST_DRAIN);
  assign out_o.sorted_value = cell_val[0];
  assign out_o.final_res    = (count_q == CntOne);
  assign out_o.overflow     = dropped_q;
  assign out_acc            = out_o.valid && out_o.ready;

  assign ctrl.ins   = in_acc && has_room;
  assign ctrl.shift = out_acc;
  assign ctrl.value = in_i.value;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + CntOne;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_d = count_q - CntOne;
          if (count_q == CntOne) begin
            // last result of the set taken: ready for the next set
            state_d   = ST_FILL;
            dropped_d = 1'b0;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  // The chain: entry i is occupied when i is below the count; occupied
  // entries are ascending, so the greater-than flags form a suffix.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic           occ, left_gt;
    ise_pkg::data_t left_val, right_val;

    assign occ = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = in_i.value;
    end else begin : g_body
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    ise_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ),
      .left_gt_i  (left_gt),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .gt_o       (cell_gt[i]),
      .val_o      (cell_val[i])
    );
  end

endmodule

`default_nettype wire
